// ===== hdl/dgl_pkg.sv =====
// dgl_pkg: shared types, constants and functions of the dithered gradient line
// generator. no dependencies; used by every module in hdl/ through scoped names.
`default_nettype none
package dgl_pkg;

    localparam int CHAN_W      = 24;   // 8.16 channel value on the input
    localparam int COUNT_W     = 16;   // pixel count
    localparam int ACC_W       = 32;   // accumulators and steps
    localparam int LANE_W      = 16;   // one dither lane
    localparam int NUM_CH      = 4;
    localparam int IN_DATA_W   = 8 * CHAN_W + COUNT_W;
    localparam int PIX_W       = 32;
    localparam int DIV_STEPS   = CHAN_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // channel slots inside the datapath
    localparam int CH_A = 0;
    localparam int CH_R = 1;
    localparam int CH_G = 2;
    localparam int CH_B = 3;

    // item kinds on tuser
    localparam logic OP_SETUP = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [63:0] DITHER_FACTOR = 64'hbb75bb75bb75bb75;
    localparam logic [63:0] DITHER_SEED   = 64'ha9d1878556c9bcdd;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DIV   = 3'b010,
        ST_WRITE = 3'b100
    } dgl_state_t;

    // controller to datapath
    typedef struct packed {
        logic setup;        // setup transaction accepted this cycle
        logic pixel;        // pixel transaction accepted this cycle
        logic div_step;     // one divider iteration
        logic write_steps;  // quotients are final, load step registers
    } dgl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_space;    // output buffer can take one more pixel
    } dgl_status_t;

    // divider control
    typedef struct packed {
        logic load;
        logic step;
    } dgl_div_ctl_t;

    // each lane times its factor, mod 2^16
    function automatic logic [63:0] advance_lanes(input logic [63:0] lanes);
        logic [63:0] res;
        res = '0;
        for (int i = 0; i < 4; i++)
        begin
            res[16*i +: 16] = lanes[16*i +: 16] * DITHER_FACTOR[16*i +: 16];
        end
        return res;
    endfunction

    // lanes register holds the already advanced value, one pixel ahead
    localparam logic [63:0] LANES_INIT = advance_lanes(DITHER_SEED);

    // lane 0 dithers green, lane 1 alpha, lane 2 blue, lane 3 red
    function automatic logic [LANE_W-1:0] lane_for(input logic [63:0] lanes, input int ch);
        logic [LANE_W-1:0] l;
        unique case (ch)
            CH_A:    l = lanes[31:16];
            CH_R:    l = lanes[63:48];
            CH_G:    l = lanes[15:0];
            default: l = lanes[47:32];
        endcase
        return l;
    endfunction

    // bits 31:16 of acc + lane, signed, clamped to 0..255
    function automatic logic [7:0] chan_byte(input logic [ACC_W-1:0] acc,
                                             input logic [LANE_W-1:0] lane);
        logic [ACC_W-1:0] sum;
        logic [15:0]      hi;
        logic [7:0]       b;
        sum = acc + {16'd0, lane};
        hi  = sum[31:16];
        priority if (hi[15])
            b = 8'd0;
        else if (hi[14:8] != 7'd0)
            b = 8'hff;
        else
            b = hi[7:0];
        return b;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/dgl_div.sv =====
// dgl_div: restoring divider, one quotient bit per step, 24-bit by 16-bit.
// depends on dgl_pkg.
`default_nettype none
module dgl_div (
    input  wire logic                           clk,
    input  wire dgl_pkg::dgl_div_ctl_t          ctl,
    input  wire logic [dgl_pkg::CHAN_W-1:0]     dividend,
    input  wire logic [dgl_pkg::COUNT_W-1:0]    divisor,
    output logic      [dgl_pkg::CHAN_W-1:0]     quotient
);

    logic [dgl_pkg::CHAN_W-1:0]  quo_reg, quo_next;
    logic [dgl_pkg::COUNT_W-1:0] rem_reg, rem_next;
    logic [dgl_pkg::COUNT_W-1:0] dvs_reg, dvs_next;
    logic [dgl_pkg::COUNT_W:0]   trial;
    logic [dgl_pkg::COUNT_W:0]   diff;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[dgl_pkg::CHAN_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        priority if (ctl.load)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (ctl.step)
        begin
            // remainder stays below the divisor, so 16 bits hold it
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[dgl_pkg::COUNT_W-1:0];
                quo_next = {quo_reg[dgl_pkg::CHAN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[dgl_pkg::COUNT_W-1:0];
                quo_next = {quo_reg[dgl_pkg::CHAN_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ===== hdl/dgl_ctrl.sv =====
// dgl_ctrl: controller state machine, input handshake and divider sequencing.
// depends on dgl_pkg.
`default_nettype none
module dgl_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tuser,
    output logic                      s_tready,
    input  wire dgl_pkg::dgl_status_t status,
    output dgl_pkg::dgl_cmd_t         cmd
);

    dgl_pkg::dgl_state_t              state_reg, state_next;
    logic [dgl_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                             accept;

    assign s_tready = (state_reg == dgl_pkg::ST_IDLE) && status.out_space;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        cmd.setup        = 1'b0;
        cmd.pixel        = 1'b0;
        cmd.div_step     = 1'b0;
        cmd.write_steps  = 1'b0;
        unique case (state_reg)
            dgl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == dgl_pkg::OP_SETUP)
                    begin
                        cmd.setup  = 1'b1;
                        cnt_next   = '0;
                        state_next = dgl_pkg::ST_DIV;
                    end
                    else
                    begin
                        cmd.pixel = 1'b1;
                    end
                end
            end
            dgl_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + dgl_pkg::DIV_CNT_W'(1);
                if (cnt_reg == dgl_pkg::DIV_CNT_W'(dgl_pkg::DIV_STEPS - 1))
                    state_next = dgl_pkg::ST_WRITE;
            end
            dgl_pkg::ST_WRITE:
            begin
                cmd.write_steps = 1'b1;
                state_next      = dgl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dgl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dgl_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/dgl_datapath.sv =====
// dgl_datapath: accumulators, steps, dither lanes, step dividers, pixel
// formation and a two-entry output buffer. depends on dgl_pkg and dgl_div.
`default_nettype none
module dgl_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire dgl_pkg::dgl_cmd_t                cmd,
    input  wire logic [dgl_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire logic                             m_tready,
    output logic                                  m_tvalid,
    output logic      [dgl_pkg::PIX_W-1:0]        m_tdata,
    output dgl_pkg::dgl_status_t                  status
);

    localparam int CW = dgl_pkg::CHAN_W;
    localparam int AW = dgl_pkg::ACC_W;

    logic [AW-1:0]            acc_reg  [dgl_pkg::NUM_CH];
    logic [AW-1:0]            acc_next [dgl_pkg::NUM_CH];
    logic [AW-1:0]            step_reg  [dgl_pkg::NUM_CH];
    logic [AW-1:0]            step_next [dgl_pkg::NUM_CH];
    logic                     neg_reg  [dgl_pkg::NUM_CH];
    logic                     neg_next [dgl_pkg::NUM_CH];
    logic [63:0]              lanes_reg, lanes_next;

    logic [CW-1:0]            start_val [dgl_pkg::NUM_CH];
    logic [CW-1:0]            end_val   [dgl_pkg::NUM_CH];
    logic [CW-1:0]            mag       [dgl_pkg::NUM_CH];
    logic [CW-1:0]            quo       [dgl_pkg::NUM_CH];
    logic [dgl_pkg::COUNT_W-1:0] count;
    logic [dgl_pkg::COUNT_W-1:0] dmag;
    logic [7:0]               chan [dgl_pkg::NUM_CH];
    logic [dgl_pkg::PIX_W-1:0] pixel;

    logic [dgl_pkg::PIX_W-1:0] out_reg, out_next, skid_reg, skid_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      skid_valid_reg, skid_valid_next;

    dgl_pkg::dgl_div_ctl_t     div_ctl;

    // field unpack, start values then end values then pixel count
    always_comb
    begin
        for (int c = 0; c < dgl_pkg::NUM_CH; c++)
        begin
            start_val[c] = s_tdata[CW*c +: CW];
            end_val[c]   = s_tdata[CW*(c+4) +: CW];
        end
        count = s_tdata[dgl_pkg::IN_DATA_W-1 -: dgl_pkg::COUNT_W];
    end

    // count 0 and 1 both divide by one; count 0 flips the sign
    assign dmag = (count <= dgl_pkg::COUNT_W'(1)) ? dgl_pkg::COUNT_W'(1)
                                                  : count - dgl_pkg::COUNT_W'(1);

    assign div_ctl.load = cmd.setup;
    assign div_ctl.step = cmd.div_step;

    for (genvar g = 0; g < dgl_pkg::NUM_CH; g++)
    begin : g_div
        assign mag[g] = (end_val[g] < start_val[g]) ? start_val[g] - end_val[g]
                                                    : end_val[g] - start_val[g];
        dgl_div u_div (
            .clk      (clk),
            .ctl      (div_ctl),
            .dividend (mag[g]),
            .divisor  (dmag),
            .quotient (quo[g])
        );
    end

    always_comb
    begin
        for (int c = 0; c < dgl_pkg::NUM_CH; c++)
        begin
            chan[c] = dgl_pkg::chan_byte(acc_reg[c], dgl_pkg::lane_for(lanes_reg, c));
        end
        pixel = {chan[dgl_pkg::CH_A], chan[dgl_pkg::CH_R],
                 chan[dgl_pkg::CH_G], chan[dgl_pkg::CH_B]};
    end

    always_comb
    begin
        lanes_next = lanes_reg;
        for (int c = 0; c < dgl_pkg::NUM_CH; c++)
        begin
            acc_next[c]  = acc_reg[c];
            step_next[c] = step_reg[c];
            neg_next[c]  = neg_reg[c];
            if (cmd.setup)
            begin
                acc_next[c] = {{(AW-CW){1'b0}}, start_val[c]};
                neg_next[c] = (end_val[c] < start_val[c]) ^ (count == '0);
            end
            else if (cmd.pixel)
            begin
                acc_next[c] = acc_reg[c] + step_reg[c];
            end
            if (cmd.write_steps)
            begin
                step_next[c] = neg_reg[c] ? ('0 - {{(AW-CW){1'b0}}, quo[c]})
                                          : {{(AW-CW){1'b0}}, quo[c]};
            end
        end
        if (cmd.pixel)
            lanes_next = dgl_pkg::advance_lanes(lanes_reg);
    end

    // two-entry output buffer, skid entry fills only when the head is stalled
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (cmd.pixel)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_next       = pixel;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_next       = pixel;
                out_valid_next = 1'b1;
            end
        end
        else if (out_valid_reg && m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < dgl_pkg::NUM_CH; c++)
            begin
                acc_reg[c]  <= '0;
                step_reg[c] <= '0;
                neg_reg[c]  <= 1'b0;
            end
            lanes_reg      <= dgl_pkg::LANES_INIT;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            for (int c = 0; c < dgl_pkg::NUM_CH; c++)
            begin
                acc_reg[c]  <= acc_next[c];
                step_reg[c] <= step_next[c];
                neg_reg[c]  <= neg_next[c];
            end
            lanes_reg      <= lanes_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid         = out_valid_reg;
    assign m_tdata          = out_reg;
    assign status.out_space = !skid_valid_reg;

endmodule
`default_nettype wire

// ===== hdl/dithered_gradient_line.sv =====
// dithered_gradient_line: top level of the dithered line gradient generator.
// depends on dgl_pkg, dgl_ctrl, dgl_datapath (and dgl_div below it).
//
// channel  direction  signals                          transaction
// s_       in         s_tvalid s_tready s_tdata s_tuser one setup or pixel item
// m_       out        m_tvalid m_tready m_tdata         one packed argb pixel
//
// pixels stream at one per cycle while the output buffer has room for them
// a setup transaction holds s_tready low through the division and step write: four
//   restoring dividers, one quotient bit per cycle over 24 bits, then a step write
// reset (rst_n, async) clears accumulators and steps and reseeds the dither lanes
// a stalled m_tready is absorbed by a two-entry output buffer; s_tready drops
//   only once both entries hold pixels (it also stays low during a setup)
`default_nettype none
module dithered_gradient_line (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata, low bit up: start_alpha, start_red, start_green, start_blue,
    // end_alpha, end_red, end_green, end_blue (24 bits each), pixel_count (16)
    input  wire logic [dgl_pkg::IN_DATA_W-1:0]      s_tdata,
    // s_tuser: op (0 = setup a line, 1 = emit next pixel)
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata: pixel_argb (blue 7:0, green 15:8, red 23:16, alpha 31:24)
    output logic      [dgl_pkg::PIX_W-1:0]          m_tdata
);

    dgl_pkg::dgl_cmd_t    cmd;
    dgl_pkg::dgl_status_t status;

    // sequencing and input handshake
    dgl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // gradient state, dividers, dither and output buffer
    dgl_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .status   (status)
    );

    // a setup keeps the input closed while the dividers run
    a_setup_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == dgl_pkg::OP_SETUP)) |=> !s_tready)
        else $error("input accepted during step division");

    // after an accepted pixel the output is valid in the next cycle
    a_pixel_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == dgl_pkg::OP_PIXEL)) |=> m_tvalid)
        else $error("accepted pixel not presented");

    // the skid entry is never filled with the head empty
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        !status.out_space |-> m_tvalid)
        else $error("skid entry full with empty output head");

    // no divider activity outside a setup
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step || cmd.write_steps) |-> !s_tready)
        else $error("divider running while input open");

endmodule
`default_nettype wire

// ===== dv/tb_dithered_gradient_line.sv =====
// tb_dithered_gradient_line: self-checking testbench for the dithered line gradient
// generator. depends on dgl_pkg and the rtl under hdl/; drives setup and pixel
// transactions with random idling and checks every pixel against a local predictor
`default_nettype none
module tb_dithered_gradient_line;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either side
    localparam int LONG_HOLD      = 90;    // one long receiver stall, in cycles
    localparam int DRAIN_CYCLES   = 40;    // covers a setup plus pipeline

    // one input transaction; channel slots follow CH_A..CH_B, slot 0 lowest in tdata
    typedef struct packed {
        logic                                            op;
        logic [dgl_pkg::NUM_CH-1:0][dgl_pkg::CHAN_W-1:0] to_ch;
        logic [dgl_pkg::NUM_CH-1:0][dgl_pkg::CHAN_W-1:0] from_ch;
        logic [dgl_pkg::COUNT_W-1:0]                     count;
    } line_item_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    // dut ports, the driven inputs all known from time zero
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [dgl_pkg::IN_DATA_W-1:0] s_tdata  = '0;
    logic                          s_tuser  = dgl_pkg::OP_SETUP;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [dgl_pkg::PIX_W-1:0]     m_tdata;

    dithered_gradient_line u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // stimulus and scoreboard storage
    line_item_t                pending_items[$];
    logic [dgl_pkg::PIX_W-1:0] expected_pixels[$];
    line_item_t                cur_item;
    int                        errors      = 0;
    int                        pixels_seen = 0;
    bit                        idle_on     = 1'b0;   // random idling bursts on both sides
    bit                        rx_hold_req = 1'b0;   // asks the receiver for one long stall

    // predictor state: accumulators, per-pixel increments and the dither lanes
    logic [dgl_pkg::NUM_CH-1:0][dgl_pkg::ACC_W-1:0] grad_acc;
    logic [dgl_pkg::NUM_CH-1:0][dgl_pkg::ACC_W-1:0] grad_inc;
    logic [63:0]                                    dither_state;

    // (to - from) / (count - 1) truncated toward zero; count 1 means no division,
    // count 0 divides by -1 and just flips the sign
    function automatic logic [dgl_pkg::ACC_W-1:0] gradient_increment(
        input logic [dgl_pkg::CHAN_W-1:0]  from_v,
        input logic [dgl_pkg::CHAN_W-1:0]  to_v,
        input logic [dgl_pkg::COUNT_W-1:0] count);
        int                        divisor;
        logic                      down;
        logic [dgl_pkg::ACC_W-1:0] mag;
        divisor = int'(count) - 1;
        down    = to_v < from_v;
        mag     = down ? ({8'd0, from_v} - {8'd0, to_v}) : ({8'd0, to_v} - {8'd0, from_v});
        if (divisor < 0)
            down = !down;
        else if (divisor > 0)
            mag = mag / divisor[31:0];
        return down ? (32'd0 - mag) : mag;
    endfunction

    // lane 0 dithers green, lane 1 alpha, lane 2 blue, lane 3 red
    function automatic logic [dgl_pkg::LANE_W-1:0] dither_for(input logic [63:0] lanes,
                                                              input int ch);
        logic [dgl_pkg::LANE_W-1:0] l;
        case (ch)
            dgl_pkg::CH_A: l = lanes[16 +: 16];
            dgl_pkg::CH_R: l = lanes[48 +: 16];
            dgl_pkg::CH_G: l = lanes[0 +: 16];
            default:       l = lanes[32 +: 16];
        endcase
        return l;
    endfunction

    // upper half of the dithered sum read as signed, clamped to one byte
    function automatic logic [7:0] clamp_channel(input logic [dgl_pkg::ACC_W-1:0] acc,
                                                 input logic [dgl_pkg::LANE_W-1:0] lane);
        logic [dgl_pkg::ACC_W-1:0] sum;
        logic signed [15:0]        level;
        sum   = acc + {16'd0, lane};
        level = signed'(sum[31:16]);
        if (level < 0)
            return 8'd0;
        else if (level > 255)
            return 8'hff;
        return level[7:0];
    endfunction

    // advance the predictor by one accepted transaction
    task automatic apply_item(input line_item_t it);
        logic [3:0][7:0] argb;
        if (it.op == dgl_pkg::OP_SETUP)
        begin
            for (int c = 0; c < dgl_pkg::NUM_CH; c++)
            begin
                grad_acc[c] = {8'd0, it.from_ch[c]};
                grad_inc[c] = gradient_increment(it.from_ch[c], it.to_ch[c], it.count);
            end
        end
        else
        begin
            // multiplicative lanes, each mod 2^16, moved before use
            for (int i = 0; i < 4; i++)
            begin
                dither_state[16*i +: 16] = dither_state[16*i +: 16]
                                         * dgl_pkg::DITHER_FACTOR[16*i +: 16];
            end
            argb[3] = clamp_channel(grad_acc[dgl_pkg::CH_A],
                                    dither_for(dither_state, dgl_pkg::CH_A));
            argb[2] = clamp_channel(grad_acc[dgl_pkg::CH_R],
                                    dither_for(dither_state, dgl_pkg::CH_R));
            argb[1] = clamp_channel(grad_acc[dgl_pkg::CH_G],
                                    dither_for(dither_state, dgl_pkg::CH_G));
            argb[0] = clamp_channel(grad_acc[dgl_pkg::CH_B],
                                    dither_for(dither_state, dgl_pkg::CH_B));
            expected_pixels.push_back(argb);
            for (int c = 0; c < dgl_pkg::NUM_CH; c++)
                grad_acc[c] = grad_acc[c] + grad_inc[c];
        end
    endtask

    // driver: holds the offered transaction until accepted, then takes the next
    int tx_gap = 0;

    always @(posedge clk)
    begin : driver
        line_item_t nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                apply_item(cur_item);
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    nxt = pending_items.pop_front();
                    cur_item <= nxt;
                    s_tdata  <= {nxt.count, nxt.to_ch, nxt.from_ch};
                    s_tuser  <= nxt.op;
                    s_tvalid <= 1'b1;
                    if (idle_on && $urandom_range(0, 7) == 0)
                        tx_gap <= $urandom_range(1, 13);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each pixel transaction and drives m_tready
    int rx_stall    = 0;
    bit rx_hold_got = 1'b0;

    always @(posedge clk)
    begin : monitor
        logic [dgl_pkg::PIX_W-1:0] want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected pixel %08h with nothing pending", m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (m_tdata !== want)
                    begin
                        if (errors < 10)
                            $display("pixel %0d mismatch: expected argb %08h, got %08h",
                                     pixels_seen, want, m_tdata);
                        errors++;
                    end
                end
                pixels_seen++;
            end
            // long stall first, then random bursts
            if (rx_hold_req && !rx_hold_got)
            begin
                rx_hold_got <= 1'b1;
                rx_stall    <= LONG_HOLD;
                m_tready    <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall <= rx_stall - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 6) == 0)
                    rx_stall <= $urandom_range(1, 13);
            end
        end
    end

    // watchdog: ends a run that stops moving
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // stimulus helpers
    function automatic logic [dgl_pkg::CHAN_W-1:0] rand_level();
        logic [dgl_pkg::CHAN_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            2:       v = dgl_pkg::CHAN_W'($urandom_range(0, 255));
            3:       v = 24'hffffff - dgl_pkg::CHAN_W'($urandom_range(0, 65535));
            default: v = dgl_pkg::CHAN_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic push_setup(input logic [dgl_pkg::NUM_CH-1:0][dgl_pkg::CHAN_W-1:0] from_ch,
                              input logic [dgl_pkg::NUM_CH-1:0][dgl_pkg::CHAN_W-1:0] to_ch,
                              input logic [dgl_pkg::COUNT_W-1:0] count);
        line_item_t it;
        it.op      = dgl_pkg::OP_SETUP;
        it.from_ch = from_ch;
        it.to_ch   = to_ch;
        it.count   = count;
        pending_items.push_back(it);
    endtask

    // pixel transactions carry random junk in the setup-only fields
    task automatic push_pixels(input int n);
        line_item_t it;
        for (int i = 0; i < n; i++)
        begin
            it.op = dgl_pkg::OP_PIXEL;
            for (int c = 0; c < dgl_pkg::NUM_CH; c++)
            begin
                it.from_ch[c] = dgl_pkg::CHAN_W'($urandom);
                it.to_ch[c]   = dgl_pkg::CHAN_W'($urandom);
            end
            it.count = dgl_pkg::COUNT_W'($urandom);
            pending_items.push_back(it);
        end
    endtask

    // one random line, mostly well formed; returns the number of transactions queued
    task automatic push_random_line(output int n_items);
        logic [dgl_pkg::NUM_CH-1:0][dgl_pkg::CHAN_W-1:0] from_ch;
        logic [dgl_pkg::NUM_CH-1:0][dgl_pkg::CHAN_W-1:0] to_ch;
        logic [dgl_pkg::COUNT_W-1:0]                     count;
        int                                              n_px;
        for (int c = 0; c < dgl_pkg::NUM_CH; c++)
        begin
            from_ch[c] = rand_level();
            to_ch[c]   = rand_level();
        end
        case ($urandom_range(0, 9))
            0:
            begin
                // stray pixels continuing whatever line is active
                n_px = $urandom_range(1, 3);
                push_pixels(n_px);
                n_items = n_px;
            end
            1:
            begin
                // setup that is overridden or never used
                push_setup(from_ch, to_ch, dgl_pkg::COUNT_W'($urandom));
                n_items = 1;
            end
            default:
            begin
                if ($urandom_range(0, 7) == 0)
                    count = dgl_pkg::COUNT_W'($urandom);
                else
                    count = dgl_pkg::COUNT_W'($urandom_range(0, 24));
                if (count > 24)
                    n_px = $urandom_range(1, 24);
                else if ($urandom_range(0, 3) == 0)
                    n_px = int'(count) + $urandom_range(1, 3);   // run past the end
                else
                    n_px = int'(count);
                push_setup(from_ch, to_ch, count);
                push_pixels(n_px);
                n_items = n_px + 1;
            end
        endcase
    endtask

    // pause the sender until everything offered has been accepted and checked
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // main sequence
    initial
    begin
        int n_rand;
        int n_line;
        grad_acc     = '0;
        grad_inc     = '0;
        dither_state = dgl_pkg::DITHER_SEED;
        n_rand       = 0;
        n_line       = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        push_pixels(2);                                  // pixels before any setup
        push_setup('0, '1, 16'd4);                       // rising ramp, run past the end
        push_pixels(5);
        push_setup('1, '0, 16'd3);                       // falling ramp goes negative
        push_pixels(5);
        push_setup({24'h000100, 24'hff0000, 24'h123456, 24'h00ffff},
                   {24'hffffff, 24'h000001, 24'hfedcba, 24'h800000}, 16'd1);   // single pixel
        push_pixels(2);
        push_setup({24'h00ff00, 24'h7fffff, 24'h000000, 24'hffffff},
                   {24'hff00ff, 24'h800000, 24'h000001, 24'h000000}, 16'd0);   // empty line
        push_pixels(2);
        push_setup('0, '1, 16'hffff);                    // longest line
        push_pixels(1);
        push_setup('1, '1, 16'd2);                       // dither carries past 255
        push_pixels(2);
        wait_drained();

        // receiver stalls for a long stretch while the sender keeps offering
        push_setup({24'h100000, 24'h200000, 24'h300000, 24'h400000},
                   {24'hf00000, 24'he00000, 24'hd00000, 24'hc00000}, 16'd20);
        push_pixels(20);
        rx_hold_req = 1'b1;
        wait_drained();

        // random part, idling toggled per line
        while (n_rand < 440)
        begin
            idle_on = ($urandom_range(0, 4) != 0);
            push_random_line(n_line);
            n_rand += n_line;
            while (pending_items.size() > 4)
                @(posedge clk);
        end

        // last part runs without idling
        idle_on = 1'b0;
        n_rand  = 0;
        while (n_rand < 60)
        begin
            push_random_line(n_line);
            n_rand += n_line;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            $display("%0d expected pixels never arrived", expected_pixels.size());
            errors++;
        end
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
